// ===== design/srk4_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srk4_pkg
// Shared types, command codes and fixed-point helpers for the SEIRS RK4 block.
// ----------------------------------------------------------------------------
package srk4_pkg;

  localparam int FRAC_BITS = 30;
  localparam int ACC_W     = 35;

  // datapath command codes
  localparam logic [3:0] OP_NOP   = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_START = 4'd2;
  localparam logic [3:0] OP_MUL   = 4'd3;
  localparam logic [3:0] OP_KUPD  = 4'd4;
  localparam logic [3:0] OP_STG   = 4'd5;
  localparam logic [3:0] OP_FIN   = 4'd6;
  localparam logic [3:0] OP_DIV   = 4'd7;
  localparam logic [3:0] OP_FWB   = 4'd8;
  localparam logic [3:0] OP_OUT   = 4'd9;

  // derivative product selectors
  localparam logic [2:0] MS_BI  = 3'd0;
  localparam logic [2:0] MS_BSI = 3'd1;
  localparam logic [2:0] MS_RR  = 3'd2;
  localparam logic [2:0] MS_SE  = 3'd3;
  localparam logic [2:0] MS_GI  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_BETA  = 3'd0;
  localparam logic [2:0] CFG_SIGMA = 3'd1;
  localparam logic [2:0] CFG_GAMMA = 3'd2;
  localparam logic [2:0] CFG_RHO   = 3'd3;
  localparam logic [2:0] CFG_DT    = 3'd4;

  // divide by six, one 16-bit digit per step: q = (v * RECIP) >> SHIFT
  localparam logic [20:0] DIV_RECIP = 21'd349526;
  localparam int          DIV_SHIFT = 21;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] sel;
    logic       phase;
    logic [1:0] eval;
  } srk4_cmd_t;

  typedef struct packed {
    logic out_free;
  } srk4_stat_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } sat_res_t;

  function automatic logic signed [63:0] sx32(input logic signed [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic sat_res_t sat32(input logic signed [63:0] v);
    sat_res_t r;
    if (v > 64'sd2147483647) begin
      r.sat = 1'b1;
      r.val = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r.sat = 1'b1;
      r.val = 32'sh80000000;
    end else begin
      r.sat = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

  // round to nearest, ties toward plus infinity
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input logic extra);
    logic signed [63:0] h0;
    logic signed [63:0] h1;
    h0 = v + (64'sd1 <<< (FRAC_BITS - 1));
    h1 = v + (64'sd1 <<< FRAC_BITS);
    return extra ? (h1 >>> (FRAC_BITS + 1)) : (h0 >>> FRAC_BITS);
  endfunction

endpackage

// ===== design/srk4_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srk4_ctrl
// Sequencer for the SEIRS RK4 step: issues datapath commands in order.
// ----------------------------------------------------------------------------
module srk4_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 in_op,
  input  srk4_pkg::srk4_stat_t stat,
  output srk4_pkg::srk4_cmd_t  cmd
);
  import srk4_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DERIV = 3'd1;
  localparam logic [2:0] S_KUPD  = 3'd2;
  localparam logic [2:0] S_STAGE = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_FWB   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [2:0] sel_r, sel_nxt;
  logic       ph_r, ph_nxt;
  logic [1:0] e_r, e_nxt;
  logic [1:0] dcnt_r, dcnt_nxt;

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    ph_nxt    = ph_r;
    e_nxt     = e_r;
    dcnt_nxt  = dcnt_r;
    cmd.op    = OP_NOP;
    cmd.sel   = sel_r;
    cmd.phase = ph_r;
    cmd.eval  = e_r;
    in_tready = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          sel_nxt = 3'd0;
          ph_nxt  = 1'b0;
          e_nxt   = 2'd0;
          if (in_op) begin
            cmd.op    = OP_START;
            state_nxt = S_DERIV;
          end else begin
            cmd.op    = OP_LOAD;
            state_nxt = S_OUT;
          end
        end
      end
      S_DERIV: begin
        cmd.op = OP_MUL;
        ph_nxt = ~ph_r;
        if (ph_r) begin
          if (sel_r == MS_GI) begin
            sel_nxt   = 3'd0;
            state_nxt = S_KUPD;
          end else begin
            sel_nxt = sel_r + 3'd1;
          end
        end
      end
      S_KUPD: begin
        cmd.op    = OP_KUPD;
        sel_nxt   = 3'd0;
        ph_nxt    = 1'b0;
        state_nxt = (e_r == 2'd3) ? S_FIN : S_STAGE;
      end
      S_STAGE: begin
        cmd.op = OP_STG;
        ph_nxt = ~ph_r;
        if (ph_r) begin
          if (sel_r == 3'd3) begin
            sel_nxt   = 3'd0;
            e_nxt     = e_r + 2'd1;
            state_nxt = S_DERIV;
          end else begin
            sel_nxt = sel_r + 3'd1;
          end
        end
      end
      S_FIN: begin
        cmd.op = OP_FIN;
        ph_nxt = ~ph_r;
        if (ph_r) begin
          dcnt_nxt  = 2'd0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.op   = OP_DIV;
        dcnt_nxt = dcnt_r + 2'd1;
        if (dcnt_r == 2'd3) state_nxt = S_FWB;
      end
      S_FWB: begin
        cmd.op = OP_FWB;
        ph_nxt = 1'b0;
        if (sel_r == 3'd3) begin
          state_nxt = S_OUT;
        end else begin
          sel_nxt   = sel_r + 3'd1;
          state_nxt = S_FIN;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= 3'd0;
      ph_r    <= 1'b0;
      e_r     <= 2'd0;
      dcnt_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      ph_r    <= ph_nxt;
      e_r     <= e_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

endmodule

// ===== design/srk4_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srk4_dpath
// SEIRS RK4 datapath: state, one shared multiplier, divide-by-six unit.
// ----------------------------------------------------------------------------
module srk4_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  srk4_pkg::srk4_cmd_t  cmd,
  output srk4_pkg::srk4_stat_t stat,
  input  logic [127:0]         in_tdata,
  input  logic                 cfg_valid,
  input  logic [2:0]           cfg_index,
  input  logic [30:0]          cfg_data,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [159:0]         out_tdata,
  output logic                 out_tuser
);
  import srk4_pkg::*;

  logic [30:0] beta_r, sigma_r, gamma_r, rho_r, dt_r;

  logic signed [31:0]      y_r   [4];
  logic signed [31:0]      p_r   [4];
  logic signed [31:0]      k_r   [4];
  logic signed [ACC_W-1:0] acc_r [4];
  logic signed [31:0]      t_r, bsi_r, rr_r, se_r, gi_r;
  logic signed [63:0]      prod_r;
  logic [63:0]             num_r, quo_r;
  logic [2:0]              rem_r;
  logic                    neg_r, sat_r;
  logic [31:0]             cnt_r;
  logic [159:0]            out_data_r;
  logic                    out_sat_r, out_valid_r;

  logic [1:0]              c;
  logic signed [31:0]      mul_a, mul_b, dt_s;
  logic                    extra;
  sat_res_t                fin_sat, wb_sat, stg_sat, inc_sat, fwb_sat;
  sat_res_t                kn [4];
  logic                    kn_any;
  logic signed [ACC_W-1:0] acc_n [4];
  logic signed [ACC_W-1:0] kx;
  logic signed [63:0]      qs;
  logic [63:0]             mag;
  logic [18:0]             dv, q6, dres;
  logic [39:0]             dprod;
  logic [15:0]             qd;

  assign c     = cmd.sel[1:0];
  assign dt_s  = $signed({1'b0, dt_r});
  assign extra = (cmd.op == OP_STG) && (cmd.eval != 2'd2);

  // multiplier operand select
  always_comb begin
    fin_sat = sat32({{(64 - ACC_W){acc_r[c][ACC_W-1]}}, acc_r[c]});
    mul_a   = '0;
    mul_b   = '0;
    unique case (cmd.op)
      OP_MUL: begin
        unique case (cmd.sel)
          MS_BI:  begin mul_a = $signed({1'b0, beta_r});  mul_b = p_r[2]; end
          MS_BSI: begin mul_a = t_r;                      mul_b = p_r[0]; end
          MS_RR:  begin mul_a = $signed({1'b0, rho_r});   mul_b = p_r[3]; end
          MS_SE:  begin mul_a = $signed({1'b0, sigma_r}); mul_b = p_r[1]; end
          default: begin mul_a = $signed({1'b0, gamma_r}); mul_b = p_r[2]; end
        endcase
      end
      OP_STG:  begin mul_a = k_r[c];      mul_b = dt_s; end
      OP_FIN:  begin mul_a = fin_sat.val; mul_b = dt_s; end
      default: begin mul_a = '0;          mul_b = '0;   end
    endcase
  end

  // product write-back and stage point
  assign wb_sat  = sat32(rnd_shift(prod_r, extra));
  assign stg_sat = sat32(sx32(y_r[c]) + sx32(wb_sat.val));

  // derivative and weighted accumulation
  always_comb begin
    kn[0]  = sat32(sx32(rr_r)  - sx32(bsi_r));
    kn[1]  = sat32(sx32(bsi_r) - sx32(se_r));
    kn[2]  = sat32(sx32(se_r)  - sx32(gi_r));
    kn[3]  = sat32(sx32(gi_r)  - sx32(rr_r));
    kn_any = kn[0].sat | kn[1].sat | kn[2].sat | kn[3].sat;
    kx     = '0;
    for (int j = 0; j < 4; j++) begin
      kx = {{(ACC_W - 32){kn[j].val[31]}}, kn[j].val};
      if (cmd.eval == 2'd0)      acc_n[j] = kx;
      else if (cmd.eval == 2'd3) acc_n[j] = acc_r[j] + kx;
      else                       acc_n[j] = acc_r[j] + (kx <<< 1);
    end
  end

  // divide-by-six digit step
  assign mag   = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
  assign dv    = {rem_r, num_r[63:48]};
  assign dprod = {21'd0, dv} * {19'd0, DIV_RECIP};
  assign qd    = dprod[DIV_SHIFT+15:DIV_SHIFT];
  assign q6    = {3'd0, qd} * 19'd6;
  assign dres  = dv - q6;

  // final increment and update
  assign qs      = neg_r ? -$signed(quo_r) : $signed(quo_r);
  assign inc_sat = sat32(rnd_shift(qs, 1'b0));
  assign fwb_sat = sat32(sx32(y_r[c]) + sx32(inc_sat.val));

  assign stat.out_free = !out_valid_r || out_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r  <= 31'd536870912;
      sigma_r <= 31'd357913941;
      gamma_r <= 31'd153391689;
      rho_r   <= 31'd2941758;
      dt_r    <= 31'd10737418;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BETA:  beta_r  <= cfg_data;
        CFG_SIGMA: sigma_r <= cfg_data;
        CFG_GAMMA: gamma_r <= cfg_data;
        CFG_RHO:   rho_r   <= cfg_data;
        CFG_DT:    dt_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // state and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_r[0]      <= 32'sd1072668082;
      y_r[1]      <= 32'sd0;
      y_r[2]      <= 32'sd1073742;
      y_r[3]      <= 32'sd0;
      cnt_r       <= 32'd0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && (cmd.op != OP_OUT)) out_valid_r <= 1'b0;
      unique case (cmd.op)
        OP_LOAD: begin
          y_r[0] <= in_tdata[31:0];
          y_r[1] <= in_tdata[63:32];
          y_r[2] <= in_tdata[95:64];
          y_r[3] <= in_tdata[127:96];
          cnt_r  <= 32'd0;
          sat_r  <= 1'b0;
        end
        OP_START: begin
          p_r   <= y_r;
          cnt_r <= cnt_r + 32'd1;
          sat_r <= 1'b0;
        end
        OP_MUL: begin
          if (!cmd.phase) begin
            prod_r <= mul_a * mul_b;
          end else begin
            sat_r <= sat_r | wb_sat.sat;
            unique case (cmd.sel)
              MS_BI:   t_r   <= wb_sat.val;
              MS_BSI:  bsi_r <= wb_sat.val;
              MS_RR:   rr_r  <= wb_sat.val;
              MS_SE:   se_r  <= wb_sat.val;
              default: gi_r  <= wb_sat.val;
            endcase
          end
        end
        OP_KUPD: begin
          for (int j = 0; j < 4; j++) begin
            k_r[j]   <= kn[j].val;
            acc_r[j] <= acc_n[j];
          end
          sat_r <= sat_r | kn_any;
        end
        OP_STG: begin
          if (!cmd.phase) begin
            prod_r <= mul_a * mul_b;
          end else begin
            p_r[c] <= stg_sat.val;
            sat_r  <= sat_r | wb_sat.sat | stg_sat.sat;
          end
        end
        OP_FIN: begin
          if (!cmd.phase) begin
            prod_r <= mul_a * mul_b;
            sat_r  <= sat_r | fin_sat.sat;
          end else begin
            num_r <= mag;
            neg_r <= prod_r[63];
            rem_r <= 3'd0;
          end
        end
        OP_DIV: begin
          num_r <= {num_r[47:0], 16'd0};
          quo_r <= {quo_r[47:0], qd};
          rem_r <= dres[2:0];
        end
        OP_FWB: begin
          y_r[c] <= fwb_sat.val;
          sat_r  <= sat_r | inc_sat.sat | fwb_sat.sat;
        end
        OP_OUT: begin
          out_data_r  <= {cnt_r, y_r[3], y_r[2], y_r[1], y_r[0]};
          out_sat_r   <= sat_r;
          out_valid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

  // checks
  a_out_set: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_OUT |=> out_valid_r)
    else $error("result register not loaded");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_OUT |-> stat.out_free)
    else $error("result overwritten before taken");
  a_load_clr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_LOAD |=> cnt_r == 32'd0)
    else $error("step counter not cleared on load");

endmodule

// ===== design/seirs_rk4_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seirs_rk4_step
// SEIRS compartment model stepped by fourth-order Runge-Kutta in Q2.30.
// ----------------------------------------------------------------------------
// One item is worked at a time. A load transaction (in_tuser = 0) sets the
// state, which is then put out as the result. A step transaction (in_tuser = 1)
// does 36 products on one shared 32x32 multiplier, four derivative updates,
// and four 4-digit divide-by-six passes in the final update. The result sits
// in an output register, so the next item is taken while it waits.
// Configuration writes are always ready.
module seirs_rk4_step (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // susceptible, exposed, infectious, recovered (32 bits each)
  input  logic [127:0] in_tdata,
  // op
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // susceptible, exposed, infectious, recovered, step_index (32 bits each)
  output logic [159:0] out_tdata,
  // saturated
  output logic         out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [30:0]  cfg_data
);
  import srk4_pkg::*;

  srk4_cmd_t  cmd;
  srk4_stat_t stat;

  assign cfg_ready = 1'b1;

  srk4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  srk4_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
